>>> hw/rtl/krjd_pkg.sv
package krjd_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int INDEX_W = 8;
    localparam int CFG_W   = 8;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // register indexes (byte address divided by four)
    localparam logic [1:0] REG_REPEAT_DELAY   = 2'd0;
    localparam logic [1:0] REG_JD_DURATION    = 2'd1;
    localparam logic [1:0] REG_AUTO_HOLD      = 2'd2;
    localparam logic [1:0] REG_AUTO_HOLD_CLR  = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] RST_REPEAT_DELAY  = 8'd64;
    localparam logic [CFG_W-1:0] RST_JD_DURATION   = 8'd4;
    localparam logic [CFG_W-1:0] RST_AUTO_HOLD     = 8'd0;
    localparam logic [CFG_W-1:0] RST_AUTO_HOLD_CLR = 8'd0;

    typedef struct packed {
        logic [CFG_W-1:0] repeat_delay;
        logic [CFG_W-1:0] jd_duration;
        logic [CFG_W-1:0] auto_hold_key;
        logic [CFG_W-1:0] auto_hold_clear_key;
    } cfg_t;

    // per-key state kept in the memory
    typedef struct packed {
        logic              held;
        logic              jd_valid;
        logic              jd_lock;
        logic [TIME_W-1:0] down_time;
        logic [TIME_W-1:0] jd_time;
    } key_entry_t;

endpackage

>>> hw/rtl/krjd_cfg.sv
module krjd_cfg
    import krjd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_delay        <= RST_REPEAT_DELAY;
            cfg_reg.jd_duration         <= RST_JD_DURATION;
            cfg_reg.auto_hold_key       <= RST_AUTO_HOLD;
            cfg_reg.auto_hold_clear_key <= RST_AUTO_HOLD_CLR;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_REPEAT_DELAY:  cfg_reg.repeat_delay        <= pwdata[CFG_W-1:0];
                REG_JD_DURATION:   cfg_reg.jd_duration         <= pwdata[CFG_W-1:0];
                REG_AUTO_HOLD:     cfg_reg.auto_hold_key       <= pwdata[CFG_W-1:0];
                REG_AUTO_HOLD_CLR: cfg_reg.auto_hold_clear_key <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_sel)
            REG_REPEAT_DELAY:  prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.repeat_delay};
            REG_JD_DURATION:   prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.jd_duration};
            REG_AUTO_HOLD:     prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.auto_hold_key};
            REG_AUTO_HOLD_CLR: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.auto_hold_clear_key};
        endcase
    end

endmodule

>>> hw/rtl/key_repeat_and_just_down_tracker.sv
// Key auto-repeat and just-down tracker.
// Input channel (s_*): one scanned key per request: index, down flag, scan time
// in ms and a scan-ok flag. Result channel (m_*): held, repeat level, just-down,
// press time and the two auto-hold flags for that key, one result per request.
// Config (APB, pready always high): 0x0 initial repeat delay, 0x4 just-down
// duration, 0x8 auto-hold key, 0xC auto-hold-clear key; change only while idle.
// A request waits in the input register, its result then in the result register.
// Throughput: one request per cycle while m_ready allows, also for repeated hits
// on one key; the single read and write ports of the key state memory set it, with
// the entry written in the same cycle bypassed into the next read.
// The per-key state sits in one memory; a written flag per key, cleared at
// reset, makes untouched keys read as zero, so no clearing pass is needed.
// Config registers return to 64, 4, 0, 0 at reset.
// When m_ready is low the result register holds and the stage in front of it
// still takes one more request; then s_ready drops until the result is taken.
module key_repeat_and_just_down_tracker
    import krjd_pkg::*;
#(
    parameter int NUM_KEYS      = 256,
    parameter int REPEAT_PERIOD = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [INDEX_W-1:0] s_key_index,
    input  logic               s_key_down,
    input  logic [TIME_W-1:0]  s_now_ms,
    input  logic               s_scan_ok,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_held,
    output logic               m_repeat_level,
    output logic               m_just_down,
    output logic [TIME_W-1:0]  m_press_time,
    output logic               m_auto_hold_on,
    output logic               m_auto_hold_reset,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    // trailing zero count of a small constant
    function automatic int trailing_zeros(input int value);
        int count;
        count = 0;
        for (int i = 0; i < 8; i++) begin
            if (count == i && value[i] == 1'b0) count = i + 1;
        end
        return count;
    endfunction

    // inverse of an odd constant modulo 2^32 (Newton iteration)
    function automatic logic [TIME_W-1:0] odd_inverse(input logic [TIME_W-1:0] d);
        logic [TIME_W-1:0] inv;
        inv = d;
        for (int i = 0; i < 5; i++) begin
            inv = inv * (32'd2 - d * inv);
        end
        return inv;
    endfunction

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // divisibility test by the repeat period: even part by mask, odd part by
    // multiply with the modular inverse and compare against the limit
    localparam int                REP_SHIFT = trailing_zeros(REPEAT_PERIOD);
    localparam logic [TIME_W-1:0] REP_ODD   = TIME_W'(REPEAT_PERIOD >> REP_SHIFT);
    localparam logic [TIME_W-1:0] REP_MASK  = (TIME_W'(1) << REP_SHIFT) - TIME_W'(1);
    localparam logic [TIME_W-1:0] REP_INV   = odd_inverse(REP_ODD);
    localparam logic [TIME_W-1:0] REP_LIMIT = 32'hFFFF_FFFF / REP_ODD;

    cfg_t cfg;

    krjd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake control
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic accept, advance;

    assign advance = s1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~s1_valid_reg | advance;
    assign accept  = s_valid & s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // input register
    logic [INDEX_W-1:0] s1_index_reg;
    logic               s1_down_reg;
    logic [TIME_W-1:0]  s1_now_reg;
    logic               s1_ok_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_index_reg <= s_key_index;
            s1_down_reg  <= s_key_down;
            s1_now_reg   <= s_now_ms;
            s1_ok_reg    <= s_scan_ok;
        end
    end

    // key state memory with write bypass
    key_entry_t          key_mem [NUM_KEYS];
    key_entry_t          rd_reg;
    key_entry_t          fwd_data_reg;
    logic                fwd_hit_reg;
    logic [NUM_KEYS-1:0] written_reg;
    logic                rd_written_reg;
    logic                wr_en;
    logic [KEY_W-1:0]    key;
    key_entry_t          wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[key] <= wr_data;
        end
        if (accept) begin
            rd_reg <= key_mem[s_key_index[KEY_W-1:0]];
        end
    end

    // written flags: an entry not written since reset reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg    <= 1'b0;
            rd_written_reg <= 1'b0;
            written_reg    <= '0;
        end else begin
            if (wr_en) begin
                written_reg[key] <= 1'b1;
            end
            if (accept) begin
                fwd_hit_reg    <= wr_en && (s_key_index == s1_index_reg);
                rd_written_reg <= written_reg[s_key_index[KEY_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_data_reg <= wr_data;
        end
    end

    // per-key update
    logic              in_range;
    key_entry_t        entry;
    logic              held_cur, jdv_cur, lock_cur;
    logic              held_new, jdv_new, lock_new;
    logic [TIME_W-1:0] down_new, jdtime_new;
    logic [TIME_W-1:0] jd_elapsed, elapsed, elapsed_odd, div_prod;
    logic              instant, level;

    assign in_range = {1'b0, s1_index_reg} < (INDEX_W + 1)'(NUM_KEYS);
    assign key      = s1_index_reg[KEY_W-1:0];
    assign entry    = fwd_hit_reg ? fwd_data_reg : (rd_written_reg ? rd_reg : '0);
    assign held_cur = entry.held;
    assign jdv_cur  = entry.jd_valid;
    assign lock_cur = entry.jd_lock;
    assign jd_elapsed = s1_now_reg - entry.jd_time;

    always_comb begin
        held_new   = held_cur;
        down_new   = entry.down_time;
        jdv_new    = jdv_cur;
        lock_new   = lock_cur;
        jdtime_new = entry.jd_time;
        if (s1_ok_reg) begin
            // held flag and press time
            if (s1_down_reg) begin
                if (!held_cur) begin
                    held_new = 1'b1;
                    down_new = s1_now_reg;
                end
            end else begin
                held_new = 1'b0;
                down_new = '0;
            end
            // just-down window
            priority if (!held_new) begin
                jdv_new  = 1'b0;
                lock_new = 1'b0;
            end else if (lock_cur) begin
                lock_new = 1'b1;
            end else if (jdv_cur) begin
                if (jd_elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.jd_duration}) begin
                    jdv_new  = 1'b0;
                    lock_new = 1'b1;
                end
            end else begin
                jdv_new    = 1'b1;
                jdtime_new = s1_now_reg;
            end
        end
    end

    // repeat instant: elapsed at or past the delay and a multiple of the period
    assign elapsed     = s1_now_reg - down_new;
    assign elapsed_odd = elapsed >> REP_SHIFT;
    assign div_prod    = elapsed_odd * REP_INV;
    assign instant     = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_delay})
                       && ((elapsed & REP_MASK) == '0)
                       && (div_prod <= REP_LIMIT);
    assign level       = s1_ok_reg & held_new & ~instant;

    assign wr_en   = advance & in_range & s1_ok_reg;
    assign wr_data = '{held: held_new, jd_valid: jdv_new, jd_lock: lock_new,
                       down_time: down_new, jd_time: jdtime_new};

    // result register
    logic              held_next, level_next, jd_next, hold_on_next, hold_reset_next;
    logic [TIME_W-1:0] press_next;
    logic              held_out_reg, level_out_reg, jd_out_reg;
    logic              hold_on_out_reg, hold_reset_out_reg;
    logic [TIME_W-1:0] press_out_reg;

    assign held_next  = in_range & held_new;
    assign level_next = in_range & level;
    assign jd_next    = in_range & jdv_new;
    assign press_next = (in_range & held_new) ? down_new : '0;
    assign hold_on_next    = level_next && (cfg.auto_hold_key != '0)
                           && (s1_index_reg == cfg.auto_hold_key);
    assign hold_reset_next = level_next && (cfg.auto_hold_clear_key != '0)
                           && (s1_index_reg == cfg.auto_hold_clear_key);

    always_ff @(posedge aclk) begin
        if (advance) begin
            held_out_reg       <= held_next;
            level_out_reg      <= level_next;
            jd_out_reg         <= jd_next;
            press_out_reg      <= press_next;
            hold_on_out_reg    <= hold_on_next;
            hold_reset_out_reg <= hold_reset_next;
        end
    end

    assign m_held            = held_out_reg;
    assign m_repeat_level    = level_out_reg;
    assign m_just_down       = jd_out_reg;
    assign m_press_time      = press_out_reg;
    assign m_auto_hold_on    = hold_on_out_reg;
    assign m_auto_hold_reset = hold_reset_out_reg;

endmodule

>>> tb/key_report_checker.sv
module key_report_checker
    import krjd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [INDEX_W-1:0] s_key_index,
    input  logic               s_key_down,
    input  logic [TIME_W-1:0]  s_now_ms,
    input  logic               s_scan_ok,
    // result channel
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_held,
    input  logic               m_repeat_level,
    input  logic               m_just_down,
    input  logic [TIME_W-1:0]  m_press_time,
    input  logic               m_auto_hold_on,
    input  logic               m_auto_hold_reset,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    input  logic               pready,
    // status to the testbench top
    output int                 mismatches,
    output int                 outstanding
);

    localparam int NUM_KEYS      = 256;
    localparam int REPEAT_PERIOD = 6;

    typedef struct packed {
        logic              held;
        logic              repeat_level;
        logic              just_down;
        logic [TIME_W-1:0] press_time;
        logic              auto_hold_on;
        logic              auto_hold_reset;
    } key_report_t;

    // shadow copy of the registers and of the per-key state
    cfg_t              cfg;
    logic              key_held  [NUM_KEYS];
    logic [TIME_W-1:0] press_at  [NUM_KEYS];
    logic              jd_on     [NUM_KEYS];
    logic [TIME_W-1:0] jd_start  [NUM_KEYS];
    logic              jd_locked [NUM_KEYS];
    key_report_t       expected_reports [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // update one key's state and work out the report it produces
    function automatic key_report_t predict_key_scan(
        input logic [INDEX_W-1:0] idx,
        input logic               down,
        input logic [TIME_W-1:0]  now,
        input logic               ok
    );
        key_report_t       rpt;
        logic [TIME_W-1:0] elapsed;
        logic              level;
        level = 1'b0;
        if (ok) begin
            // held flag and press time
            if (down) begin
                if (!key_held[idx]) begin
                    key_held[idx] = 1'b1;
                    press_at[idx] = now;
                end
            end else begin
                key_held[idx] = 1'b0;
                press_at[idx] = '0;
            end
            // just-down window, locked until the key is released
            if (!key_held[idx]) begin
                jd_on[idx]     = 1'b0;
                jd_locked[idx] = 1'b0;
            end else if (!jd_locked[idx]) begin
                if (!jd_on[idx]) begin
                    jd_on[idx]    = 1'b1;
                    jd_start[idx] = now;
                end else begin
                    elapsed = now - jd_start[idx];
                    if (elapsed > TIME_W'(cfg.jd_duration)) begin
                        jd_on[idx]     = 1'b0;
                        jd_locked[idx] = 1'b1;
                    end
                end
            end
            // repeat level drops at each repeat instant at or past the delay
            if (key_held[idx]) begin
                elapsed = now - press_at[idx];
                level = !(elapsed >= TIME_W'(cfg.repeat_delay) &&
                          (elapsed % TIME_W'(REPEAT_PERIOD)) == '0);
            end
        end
        rpt.held            = key_held[idx];
        rpt.repeat_level    = level;
        rpt.just_down       = jd_on[idx];
        rpt.press_time      = key_held[idx] ? press_at[idx] : '0;
        rpt.auto_hold_on    = level && cfg.auto_hold_key != '0 &&
                              idx == cfg.auto_hold_key;
        rpt.auto_hold_reset = level && cfg.auto_hold_clear_key != '0 &&
                              idx == cfg.auto_hold_clear_key;
        return rpt;
    endfunction

    task automatic check_field(
        input string             field,
        input logic [TIME_W-1:0] want,
        input logic [TIME_W-1:0] got
    );
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        key_report_t want;
        if (!aresetn) begin
            cfg.repeat_delay        = RST_REPEAT_DELAY;
            cfg.jd_duration         = RST_JD_DURATION;
            cfg.auto_hold_key       = RST_AUTO_HOLD;
            cfg.auto_hold_clear_key = RST_AUTO_HOLD_CLR;
            for (int k = 0; k < NUM_KEYS; k++) begin
                key_held[k]  = 1'b0;
                press_at[k]  = '0;
                jd_on[k]     = 1'b0;
                jd_start[k]  = '0;
                jd_locked[k] = 1'b0;
            end
            expected_reports.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_REPEAT_DELAY:  cfg.repeat_delay        = pwdata[CFG_W-1:0];
                    REG_JD_DURATION:   cfg.jd_duration         = pwdata[CFG_W-1:0];
                    REG_AUTO_HOLD:     cfg.auto_hold_key       = pwdata[CFG_W-1:0];
                    REG_AUTO_HOLD_CLR: cfg.auto_hold_clear_key = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            // compare a taken result with the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending, expected none, got %0h",
                             $time, m_press_time);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("held", TIME_W'(want.held), TIME_W'(m_held));
                    check_field("repeat_level", TIME_W'(want.repeat_level),
                                TIME_W'(m_repeat_level));
                    check_field("just_down", TIME_W'(want.just_down), TIME_W'(m_just_down));
                    check_field("press_time", want.press_time, m_press_time);
                    check_field("auto_hold_on", TIME_W'(want.auto_hold_on),
                                TIME_W'(m_auto_hold_on));
                    check_field("auto_hold_reset", TIME_W'(want.auto_hold_reset),
                                TIME_W'(m_auto_hold_reset));
                end
            end
            // predict each accepted request
            if (s_valid && s_ready)
                expected_reports.push_back(
                    predict_key_scan(s_key_index, s_key_down, s_now_ms, s_scan_ok));
        end
        outstanding = expected_reports.size();
    end

endmodule

>>> tb/tb.sv
module tb;
    import krjd_pkg::*;

    localparam int CYCLE_LIMIT     = 200_000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int POOL_SIZE       = 8;
    localparam int DRAIN_CYCLES    = 8;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [INDEX_W-1:0] s_key_index;
    logic               s_key_down;
    logic [TIME_W-1:0]  s_now_ms;
    logic               s_scan_ok;
    logic               m_valid;
    logic               m_ready;
    logic               m_held;
    logic               m_repeat_level;
    logic               m_just_down;
    logic [TIME_W-1:0]  m_press_time;
    logic               m_auto_hold_on;
    logic               m_auto_hold_reset;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 mismatches;
    int                 outstanding;
    int                 cycle_count = 0;
    int                 ready_pct = 100;
    bit                 hold_off_armed = 1'b0;
    bit                 hold_off_done = 1'b0;
    bit                 key_pressed [256];
    logic [TIME_W-1:0]  clock_ms;

    key_repeat_and_just_down_tracker DUT (.*);

    key_report_checker report_check (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[key_repeat_and_just_down_tracker] ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off when armed
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_armed && !hold_off_done) begin
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(posedge aclk);
                hold_off_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // keys that most random scans hit, including the auto-hold keys in use
    function automatic logic [INDEX_W-1:0] pool_key(input int n);
        case (n)
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h02;
            3: return 8'h03;
            4: return 8'h04;
            5: return 8'h7F;
            6: return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    // offer one scan and return at the edge that takes it
    task automatic send_scan(
        input logic [INDEX_W-1:0] idx,
        input logic               down,
        input logic [TIME_W-1:0]  now,
        input logic               ok
    );
        s_valid     <= 1'b1;
        s_key_index <= idx;
        s_key_down  <= down;
        s_now_ms    <= now;
        s_scan_ok   <= ok;
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    // stop offering and wait until every report has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write all four registers back to back
    task automatic apply_settings(input logic [CFG_W-1:0] delay, dur, ah_key, ah_clr_key);
        logic [1:0]       sel [4];
        logic [CFG_W-1:0] val [4];
        sel[0] = REG_REPEAT_DELAY;  val[0] = delay;
        sel[1] = REG_JD_DURATION;   val[1] = dur;
        sel[2] = REG_AUTO_HOLD;     val[2] = ah_key;
        sel[3] = REG_AUTO_HOLD_CLR; val[3] = ah_clr_key;
        for (int i = 0; i < 4; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {sel[i], 2'b00};
            pwdata  <= APB_DW'(val[i]);
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // press / hold / release sequences on pool keys, with some stray scans
    task automatic play_random(input int count, input int gap_max);
        int                 burst_left;
        logic [INDEX_W-1:0] idx;
        logic               down;
        logic               ok;
        burst_left = $urandom_range(1, 20);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 80) begin
                idx = pool_key($urandom_range(0, POOL_SIZE - 1));
                if (key_pressed[idx])
                    down = ($urandom_range(0, 19) != 0);
                else
                    down = ($urandom_range(0, 3) == 0);
                ok = ($urandom_range(0, 19) != 0);
            end else begin
                idx  = INDEX_W'($urandom_range(0, 255));
                down = 1'($urandom_range(0, 1));
                ok   = ($urandom_range(0, 3) != 0);
            end
            if (ok)
                key_pressed[idx] = down;
            // time mostly creeps forward, now and then jumps anywhere
            if ($urandom_range(0, 49) == 0)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, 3);
            send_scan(idx, down, clock_ms, ok);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                if (gap_max > 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, gap_max)) @(posedge aclk);
                end
            end
        end
    endtask

    task automatic run_phase(
        input logic [CFG_W-1:0] delay, dur, ah_key, ah_clr_key,
        input int               pct,
        input int               gap_max,
        input bit               long_hold
    );
        wait_idle();
        apply_settings(delay, dur, ah_key, ah_clr_key);
        ready_pct = pct;
        clock_ms  = $urandom();
        if (long_hold)
            hold_off_armed = 1'b1;
        play_random(75, gap_max);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_key_index = '0;
        s_key_down  = 1'b0;
        s_now_ms    = '0;
        s_scan_ok   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        clock_ms    = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: delay 64, duration 4, auto-hold off
        send_scan(8'h00, 1'b1, 32'h0000_0000, 1'b1);
        send_scan(8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // elapsed time across the wrap, pulse still on at the duration
        send_scan(8'hFF, 1'b1, 32'h0000_0003, 1'b1);
        send_scan(8'hFF, 1'b1, 32'h0000_0004, 1'b1);
        // failed scan keeps the state
        send_scan(8'hFF, 1'b1, 32'h0000_0010, 1'b0);
        send_scan(8'hFF, 1'b0, 32'h0000_0011, 1'b1);
        send_scan(8'hFF, 1'b1, 32'h0000_0012, 1'b1);
        // repeat instants only past the delay
        send_scan(8'h07, 1'b1, 32'd1000, 1'b1);
        send_scan(8'h07, 1'b1, 32'd1060, 1'b1);
        send_scan(8'h07, 1'b1, 32'd1066, 1'b1);
        send_scan(8'h07, 1'b1, 32'd1064, 1'b1);
        send_scan(8'h07, 1'b0, 32'd1070, 1'b0);
        send_scan(8'h07, 1'b0, 32'd1071, 1'b1);
        send_scan(8'h2A, 1'b0, 32'd5, 1'b0);

        // zero delay, zero duration, auto-hold keys set
        wait_idle();
        apply_settings(8'd0, 8'd0, 8'h5A, 8'hFF);
        send_scan(8'h5A, 1'b1, 32'd500, 1'b1);
        send_scan(8'h5A, 1'b1, 32'd500, 1'b1);
        send_scan(8'h5A, 1'b1, 32'd501, 1'b1);
        send_scan(8'hFF, 1'b1, 32'hFFFF_FFF0, 1'b1);
        send_scan(8'hFF, 1'b1, 32'hFFFF_FFF1, 1'b1);
        send_scan(8'hFF, 1'b1, 32'hFFFF_FFF1, 1'b0);
        send_scan(8'h5A, 1'b0, 32'd502, 1'b1);
        send_scan(8'hA5, 1'b1, 32'hAAAA_AAAA, 1'b1);
        send_scan(8'hA5, 1'b1, 32'h5555_5555, 1'b1);

        // random phases over several settings
        run_phase(8'd64,  8'd4,   8'h00, 8'h00, 100, 0, 1'b0);
        run_phase(8'd0,   8'd0,   8'h01, 8'h02, 70,  4, 1'b0);
        run_phase(8'd255, 8'd255, 8'hFF, 8'h80, 40,  3, 1'b1);
        run_phase(8'd16,  8'd1,   8'h03, 8'h00, 85,  6, 1'b0);
        run_phase(8'd6,   8'd10,  8'h00, 8'h04, 60,  2, 1'b0);
        run_phase(8'd200, 8'd128, 8'h80, 8'h7F, 90,  8, 1'b0);

        wait_idle();
        if (mismatches == 0)
            $display("[key_repeat_and_just_down_tracker] OK");
        else
            $display("[key_repeat_and_just_down_tracker] ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/krjd_pkg.sv
hw/rtl/krjd_cfg.sv
hw/rtl/key_repeat_and_just_down_tracker.sv
tb/key_report_checker.sv
tb/tb.sv
